### rtl/core/fpa_pkg.sv
// fpa_pkg: shared types and codes for the fit policy partition allocator
// used by fit_policy_partition_allocator_unit, fpa_result_checker and the testbench; no dependencies
`timescale 1ns / 1ps

package fpa_pkg;

    // request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // fit policy codes
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  partition_slot;
        logic [15:0] partition_size;
        logic [15:0] request_size;
        logic        last_request;
    } cmd_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_partition;
        logic [15:0] remaining_size;
        logic        end_of_batch;
    } result_t;

endpackage

### rtl/core/fpa_table.sv
// fpa_table: partition free size memory, one write port, one registered read port
// depends on nothing; instantiated by fit_policy_partition_allocator_unit
`timescale 1ns / 1ps

module fpa_table #(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/fit_policy_partition_allocator_unit.sv
// fit_policy_partition_allocator_unit: top level of the fit policy partition allocator
// depends on fpa_pkg and fpa_table
//
//   channel   signals                               direction
//   command   start, busy, cmd (fpa_pkg::cmd_t)     in, accepted at start & !busy
//   result    done, result (fpa_pkg::result_t)      out, one cycle strobe
//   config    cfg_valid, cfg_ready, cfg_index,      in, written at cfg_valid & cfg_ready
//             cfg_data
//
// a load request writes the table without raising busy and gives no result
// an allocation request scans min(partition_count, PARTITIONS) entries through the
// single table read port, one per cycle, then the last registered read and the decision
// follow, and on a grant a write back of the remaining size; busy stays high through
// all of these steps, the write back only when a partition fits
// done strobes in the same cycle that busy drops
// a refused request with count zero or policy three strobes done in the next cycle
// reset clears the control state and the config registers; the table is not cleared
// the receiver cannot stall, so done is never held back
`timescale 1ns / 1ps

module fit_policy_partition_allocator_unit #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fpa_pkg::cmd_t                     cmd,
    output logic                              done,
    output fpa_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW = $clog2(PARTITIONS + 1);

    fpa_pkg::state_t  state_reg, state_next;
    logic [1:0]       fit_policy_reg;
    logic [4:0]       partition_count_reg;
    logic [CW-1:0]    scan_reg, scan_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [PW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [PW-1:0]    pick_idx_reg, pick_idx_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    fpa_pkg::result_t result_reg, result_next;

    logic             accept;
    logic [CW-1:0]    limit;
    logic             policy_ok;
    logic             issue;
    logic             scan_end;
    logic             fit;
    logic             take;
    logic [SIZE_BITS-1:0] rem;

    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic [PW-1:0]    rd_addr;
    logic [SIZE_BITS-1:0] rd_data;

    fpa_table #(
        .DEPTH     (PARTITIONS),
        .ADDR_BITS (PW),
        .DATA_BITS (SIZE_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != fpa_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign limit     = (32'(partition_count_reg) > PARTITIONS) ? CW'(PARTITIONS)
                                                               : CW'(partition_count_reg);
    assign policy_ok = (fit_policy_reg == fpa_pkg::POLICY_FIRST) ||
                       (fit_policy_reg == fpa_pkg::POLICY_BEST)  ||
                       (fit_policy_reg == fpa_pkg::POLICY_WORST);
    assign issue     = (state_reg == fpa_pkg::ST_SCAN) && (scan_reg < limit);
    assign scan_end  = !issue && !cmp_valid_reg;
    assign rd_addr   = scan_reg[PW-1:0];
    assign fit       = (rd_data >= req_size_reg);
    assign rem       = pick_size_reg - req_size_reg;

    always_comb
    begin
        take = 1'b0;
        if (cmp_valid_reg && fit)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (fit_policy_reg == fpa_pkg::POLICY_BEST)
            begin
                take = (rd_data < pick_size_reg);
            end
            else if (fit_policy_reg == fpa_pkg::POLICY_WORST)
            begin
                take = (rd_data > pick_size_reg);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                if (accept && (cmd.mode == fpa_pkg::MODE_ALLOC) && policy_ok &&
                    (limit != '0))
                begin
                    state_next = fpa_pkg::ST_SCAN;
                end
            end
            fpa_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = found_reg ? fpa_pkg::ST_WRITE : fpa_pkg::ST_IDLE;
                end
            end
            fpa_pkg::ST_WRITE:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        req_size_next  = req_size_reg;
        last_next      = last_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = PW'(cmd.partition_slot);
        wr_data        = SIZE_BITS'(cmd.partition_size);
        case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == fpa_pkg::MODE_LOAD)
                    begin
                        wr_en = (32'(cmd.partition_slot) < PARTITIONS);
                    end
                    else
                    begin
                        req_size_next = SIZE_BITS'(cmd.request_size);
                        last_next     = cmd.last_request;
                        scan_next     = '0;
                        found_next    = 1'b0;
                        if (!policy_ok || (limit == '0))
                        begin
                            done_next                    = 1'b1;
                            result_next.granted          = 1'b0;
                            result_next.chosen_partition = '0;
                            result_next.remaining_size   = '0;
                            result_next.end_of_batch     = cmd.last_request;
                        end
                    end
                end
            end
            fpa_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next      = scan_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[PW-1:0];
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = cmp_idx_reg;
                    pick_size_next = rd_data;
                end
                if (scan_end && !found_reg)
                begin
                    done_next                    = 1'b1;
                    result_next.granted          = 1'b0;
                    result_next.chosen_partition = '0;
                    result_next.remaining_size   = '0;
                    result_next.end_of_batch     = last_reg;
                end
            end
            fpa_pkg::ST_WRITE:
            begin
                wr_en                        = 1'b1;
                wr_addr                      = pick_idx_reg;
                wr_data                      = rem;
                done_next                    = 1'b1;
                result_next.granted          = 1'b1;
                result_next.chosen_partition = 4'(pick_idx_reg);
                result_next.remaining_size   = 16'(rem);
                result_next.end_of_batch     = last_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= fpa_pkg::ST_IDLE;
            done_reg            <= 1'b0;
            cmp_valid_reg       <= 1'b0;
            found_reg           <= 1'b0;
            scan_reg            <= '0;
            fit_policy_reg      <= fpa_pkg::POLICY_FIRST;
            partition_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fpa_pkg::REG_FIT_POLICY:
                    begin
                        fit_policy_reg <= cfg_data[1:0];
                    end
                    fpa_pkg::REG_PARTITION_COUNT:
                    begin
                        partition_count_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                        fit_policy_reg <= fit_policy_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        req_size_reg  <= req_size_next;
        last_reg      <= last_next;
        result_reg    <= result_next;
    end

endmodule

### test/fpa_result_checker.sv
// fpa_result_checker: watches the command, config and result channels of the allocator,
// predicts each allocation result and compares it with the block's output
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  fpa_pkg::cmd_t                   cmd,
    input  logic                            done,
    input  fpa_pkg::result_t                result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending
);

    localparam int PARTITIONS = 16;

    logic [15:0]      free_size [PARTITIONS];
    logic [1:0]       policy;
    logic [4:0]       count;
    fpa_pkg::result_t expected_results [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic predict_allocation(input fpa_pkg::cmd_t c);
        int               limit;
        int               j;
        bit               searching;
        bit               found;
        logic [3:0]       pick;
        logic [15:0]      v;
        fpa_pkg::result_t r;
        searching = (policy == fpa_pkg::POLICY_FIRST) || (policy == fpa_pkg::POLICY_BEST) ||
                    (policy == fpa_pkg::POLICY_WORST);
        limit = (int'(count) > PARTITIONS) ? PARTITIONS : int'(count);
        found = 1'b0;
        pick  = '0;
        if (searching)
        begin
            for (j = 0; j < limit; j++)
            begin
                v = free_size[j];
                if (v >= c.request_size && !(found && policy == fpa_pkg::POLICY_FIRST))
                begin
                    if (!found || (policy == fpa_pkg::POLICY_BEST && v < free_size[pick]) ||
                        (policy == fpa_pkg::POLICY_WORST && v > free_size[pick]))
                        pick = 4'(j);
                    found = 1'b1;
                end
            end
        end
        if (found)
        begin
            free_size[pick]    = free_size[pick] - c.request_size;
            r.granted          = 1'b1;
            r.chosen_partition = pick;
            r.remaining_size   = free_size[pick];
        end
        else
        begin
            r.granted          = 1'b0;
            r.chosen_partition = '0;
            r.remaining_size   = '0;
        end
        r.end_of_batch = c.last_request;
        expected_results.push_back(r);
    endtask

    task automatic compare_result(input fpa_pkg::result_t act);
        fpa_pkg::result_t exp_r;
        if (expected_results.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
        end
        else
        begin
            exp_r = expected_results.pop_front();
            if (act.granted !== exp_r.granted)
            begin
                $error("granted: expected %0d, actual %0d", exp_r.granted, act.granted);
                errors++;
            end
            if (act.chosen_partition !== exp_r.chosen_partition)
            begin
                $error("chosen_partition: expected %0d, actual %0d",
                       exp_r.chosen_partition, act.chosen_partition);
                errors++;
            end
            if (act.remaining_size !== exp_r.remaining_size)
            begin
                $error("remaining_size: expected %0d, actual %0d",
                       exp_r.remaining_size, act.remaining_size);
                errors++;
            end
            if (act.end_of_batch !== exp_r.end_of_batch)
            begin
                $error("end_of_batch: expected %0d, actual %0d",
                       exp_r.end_of_batch, act.end_of_batch);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            policy = fpa_pkg::POLICY_FIRST;
            count  = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fpa_pkg::REG_FIT_POLICY)
                    policy = cfg_data[1:0];
                else if (cfg_index == fpa_pkg::REG_PARTITION_COUNT)
                    count = cfg_data[4:0];
            end
            if (done)
                compare_result(result);
            if (start && !busy)
            begin
                if (cmd.mode == fpa_pkg::MODE_LOAD)
                    free_size[cmd.partition_slot] = cmd.partition_size;
                else
                    predict_allocation(cmd);
            end
        end
        pending = expected_results.size();
    end

endmodule

### test/fit_policy_partition_allocator_unit_tb.sv
// fit_policy_partition_allocator_unit_tb: directed and random load and allocation requests
// under all fit policies and a range of partition counts, with random idle gaps on the command side
// depends on fpa_pkg, fit_policy_partition_allocator_unit and fpa_result_checker
`timescale 1ns / 1ps

module fit_policy_partition_allocator_unit_tb;

    localparam logic [1:0] POLICY_UNUSED = 2'd3;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 58;
    localparam int SETTLE_CYCLES = 25;
    localparam int STALL_LIMIT   = 1000;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    fpa_pkg::cmd_t                   cmd;
    logic                            done;
    fpa_pkg::result_t                result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fpa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              errors;
    int                              pending;
    int                              stall_cycles;

    fit_policy_partition_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fpa_result_checker result_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
        stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("fit_policy_partition_allocator_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic fpa_pkg::cmd_t make_load(input logic [3:0] slot,
                                                input logic [15:0] size);
        fpa_pkg::cmd_t c;
        c.mode           = fpa_pkg::MODE_LOAD;
        c.partition_slot = slot;
        c.partition_size = size;
        c.request_size   = 16'($urandom);
        c.last_request   = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic fpa_pkg::cmd_t make_request(input logic [15:0] size, input logic last);
        fpa_pkg::cmd_t c;
        c.mode           = fpa_pkg::MODE_ALLOC;
        c.partition_slot = 4'($urandom);
        c.partition_size = 16'($urandom);
        c.request_size   = size;
        c.last_request   = last;
        return c;
    endfunction

    function automatic logic [15:0] random_load_size();
        logic [15:0] s;
        case ($urandom_range(0, 2))
            0: case ($urandom_range(0, 3))
                   0: s = 16'd0;
                   1: s = 16'd100;
                   2: s = 16'd1000;
                   default: s = 16'hffff;
               endcase
            1: s = 16'($urandom_range(0, 4095));
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [15:0] random_request_size();
        logic [15:0] s;
        case ($urandom_range(0, 3))
            0: s = 16'($urandom_range(0, 63));
            1: s = 16'($urandom_range(0, 1023));
            2: s = 16'($urandom_range(0, 16383));
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    task automatic send(input fpa_pkg::cmd_t c, input bit idling);
        int gap;
        gap = idling ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [fpa_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fpa_pkg::CFG_DATA_W-1:0] data);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] pol, input logic [4:0] cnt);
        write_cfg(fpa_pkg::REG_FIT_POLICY, fpa_pkg::CFG_DATA_W'(pol));
        write_cfg(fpa_pkg::REG_PARTITION_COUNT, fpa_pkg::CFG_DATA_W'(cnt));
    endtask

    initial
    begin
        int          p;
        int          i;
        bit          idling;
        logic [1:0]  pol;
        logic [4:0]  cnt;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every entry before any search reads it
        set_mode(fpa_pkg::POLICY_FIRST, 5'd16);
        send(make_load(4'd0, 16'hffff), 1'b0);
        send(make_load(4'd1, 16'd0), 1'b0);
        send(make_load(4'd2, 16'd100), 1'b0);
        send(make_load(4'd3, 16'd100), 1'b0);
        for (i = 4; i < 16; i++)
            send(make_load(4'(i), random_load_size()), 1'b0);
        send(make_request(16'd0, 1'b0), 1'b0);
        send(make_request(16'hffff, 1'b0), 1'b0);
        send(make_request(16'hffff, 1'b0), 1'b1);
        send(make_request(16'd100, 1'b1), 1'b1);
        set_mode(fpa_pkg::POLICY_BEST, 5'd16);
        send(make_request(16'd50, 1'b0), 1'b0);
        send(make_request(16'd0, 1'b1), 1'b0);
        set_mode(fpa_pkg::POLICY_WORST, 5'd16);
        send(make_request(16'd1, 1'b0), 1'b0);
        send(make_request(16'd0, 1'b1), 1'b0);
        set_mode(POLICY_UNUSED, 5'd16);
        send(make_request(16'd0, 1'b1), 1'b0);
        set_mode(fpa_pkg::POLICY_FIRST, 5'd0);
        send(make_request(16'd0, 1'b1), 1'b0);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin pol = fpa_pkg::POLICY_FIRST; cnt = 5'd16; end
                1: begin pol = fpa_pkg::POLICY_BEST;  cnt = 5'd16; end
                2: begin pol = fpa_pkg::POLICY_WORST; cnt = 5'd16; end
                3: begin pol = fpa_pkg::POLICY_BEST;  cnt = 5'd1;  end
                4: begin pol = fpa_pkg::POLICY_WORST; cnt = 5'd31; end
                5: begin pol = fpa_pkg::POLICY_FIRST; cnt = 5'd17; end
                6: begin pol = POLICY_UNUSED;         cnt = 5'd8;  end
                default:
                begin
                    pol = 2'($urandom_range(0, 3));
                    cnt = 5'($urandom_range(0, 31));
                end
            endcase
            set_mode(pol, cnt);
            idling = (p % 3 != 1);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                    send(make_load(4'($urandom), random_load_size()), idling);
                else
                    send(make_request(random_request_size(), 1'($urandom_range(0, 1))),
                         idling);
            end
        end

        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("fit_policy_partition_allocator_unit_tb: PASS");
        else
            $display("fit_policy_partition_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_table.sv
rtl/core/fit_policy_partition_allocator_unit.sv
test/fpa_result_checker.sv
test/fit_policy_partition_allocator_unit_tb.sv
